/* hw/rtl/model_transform_matrix_builder_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the model transform matrix builder
// Each macro expands to one labeled concurrent assertion on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef MODEL_TRANSFORM_MATRIX_BUILDER_ASSERT_SVH
`define MODEL_TRANSFORM_MATRIX_BUILDER_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define MTMB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtmb assertion failed");

// Consequent in the cycle after the antecedent.
`define MTMB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtmb assertion failed");

`endif

/* hw/rtl/mtmb_pkg.sv */
// ----------------------------------------------------------------------------
// mtmb_pkg
// Shared constants, codes, types and fixed-point helpers of the builder.
// ----------------------------------------------------------------------------
package mtmb_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_FB    = 30;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);
  localparam int CORDIC_SH    = CORDIC_FB - FRAC_BITS;

  localparam logic signed [31:0] ONE_FIX = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  localparam logic [1:0] CMD_SET_ROT  = 2'd0;
  localparam logic [1:0] CMD_SET_MOVE = 2'd1;
  localparam logic [1:0] CMD_EMIT     = 2'd2;

  localparam logic [1:0] AXIS_X     = 2'd0;
  localparam logic [1:0] AXIS_Y     = 2'd1;
  localparam logic [1:0] AXIS_Z     = 2'd2;
  localparam logic [1:0] AXIS_SCALE = 2'd3;

  localparam logic REG_BASE_SCALE  = 1'b0;
  localparam logic REG_VERT_OFFSET = 1'b1;

  localparam logic [31:0] ATAN_TURNS [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } cordic_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = SAT_MAX[31:0];
    else if (v < SAT_MIN) r = SAT_MIN[31:0];
    else r = v[31:0];
    return r;
  endfunction

  // Round half up to FRAC_BITS fraction bits, then saturate.
  function automatic logic signed [31:0] round_frac(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sat32(t);
  endfunction

  // Entry (r, col) of the rotation matrix about axis ax.
  function automatic logic signed [31:0] rot_elem(input logic [1:0] ax,
                                                 input logic signed [31:0] c,
                                                 input logic signed [31:0] s,
                                                 input logic [1:0] r,
                                                 input logic [1:0] col);
    logic signed [31:0] e;
    e = (r == col) ? ONE_FIX : '0;
    case (ax)
      AXIS_X: begin
        if (r == 2'd1 && col == 2'd1) e = c;
        if (r == 2'd1 && col == 2'd2) e = s;
        if (r == 2'd2 && col == 2'd1) e = -s;
        if (r == 2'd2 && col == 2'd2) e = c;
      end
      AXIS_Y: begin
        if (r == 2'd0 && col == 2'd0) e = c;
        if (r == 2'd0 && col == 2'd2) e = -s;
        if (r == 2'd2 && col == 2'd0) e = s;
        if (r == 2'd2 && col == 2'd2) e = c;
      end
      AXIS_Z: begin
        if (r == 2'd0 && col == 2'd0) e = c;
        if (r == 2'd0 && col == 2'd1) e = s;
        if (r == 2'd1 && col == 2'd0) e = -s;
        if (r == 2'd1 && col == 2'd1) e = c;
      end
      default: ;
    endcase
    return e;
  endfunction

endpackage

/* hw/rtl/mtmb_ifs.sv */
// ----------------------------------------------------------------------------
// mtmb channel interfaces
// Command channel and matrix-row channel with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface mtmb_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [1:0]         axis;
  logic signed [31:0] operand_value;

  modport source(output valid, command, axis, operand_value, input ready);
  modport sink(input valid, command, axis, operand_value, output ready);
endinterface

interface mtmb_row_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic signed [31:0] col_zero;
  logic signed [31:0] col_one;
  logic signed [31:0] col_two;
  logic signed [31:0] col_three;
  logic               last_row;

  modport source(output valid, row_index, col_zero, col_one, col_two, col_three,
                 last_row, input ready);
  modport sink(input valid, row_index, col_zero, col_one, col_two, col_three,
               last_row, output ready);
endinterface

/* hw/rtl/mtmb_cordic.sv */
// ----------------------------------------------------------------------------
// mtmb_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, gives the
// rounded Q-format cosine and sine of a binary angle.
// ----------------------------------------------------------------------------
module mtmb_cordic (
  input  logic                  clk,
  input  logic                  rst,
  input  mtmb_pkg::cordic_req_t req,
  output mtmb_pkg::cordic_rsp_t rsp
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t                          state;
  logic [mtmb_pkg::ITER_W-1:0]     iter;
  logic signed [33:0]              x;
  logic signed [33:0]              y;
  logic signed [33:0]              z;
  logic                            flip;

  logic                            flip_next;
  logic [31:0]                     folded;
  logic signed [33:0]              dx;
  logic signed [33:0]              dy;
  logic signed [33:0]              atan_v;
  logic signed [31:0]              cos_r;
  logic signed [31:0]              sin_r;

  function automatic logic signed [31:0] round_cordic(input logic signed [33:0] v);
    logic signed [65:0] t;
    t = (66'(v) + (66'sd1 <<< (mtmb_pkg::CORDIC_SH - 1))) >>> mtmb_pkg::CORDIC_SH;
    return mtmb_pkg::sat32(t);
  endfunction

  // Angles in the left half-plane are folded by a half turn.
  assign flip_next = req.angle[31] ^ req.angle[30];
  assign folded    = req.angle ^ {flip_next, 31'd0};
  assign dx        = y >>> iter;
  assign dy        = x >>> iter;
  assign atan_v    = 34'(mtmb_pkg::ATAN_TURNS[5'(iter)]);
  assign cos_r     = round_cordic(x);
  assign sin_r     = round_cordic(y);

  assign rsp.done  = (state == S_DONE);
  assign rsp.cos_v = flip ? -cos_r : cos_r;
  assign rsp.sin_v = flip ? -sin_r : sin_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.start) begin
            flip  <= flip_next;
            z     <= 34'(signed'(folded));
            x     <= mtmb_pkg::CORDIC_GAIN;
            y     <= '0;
            iter  <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (!z[33]) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - atan_v;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + atan_v;
          end
          if (iter == mtmb_pkg::ITER_W'(mtmb_pkg::CORDIC_ITERS - 1)) begin
            state <= S_DONE;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/model_transform_matrix_builder.sv */
// ----------------------------------------------------------------------------
// model_transform_matrix_builder
// Builds the 4x4 model matrix Rx*Ry*Rz*M from stored angles, shifts and scale.
// ----------------------------------------------------------------------------
// Set commands are taken while idle. An emit runs the CORDIC for the three
// angles and the scale product, then the three products (12 rows) one matrix
// row at a time; each final row is sent before the next one is built, and a
// row waits as long as ready is low. The next command is taken the cycle after
// the last row. One shared 32x32 multiplier serves the scale and matrix products.
// Synchronous reset restores all stored values, the state and the valid flags.
module model_transform_matrix_builder (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  mtmb_cmd_if.sink           cmd,
  mtmb_row_if.source         rows
);

  typedef enum logic [2:0] {
    S_IDLE, S_CORDIC_START, S_CORDIC_WAIT, S_SCALE_MUL, S_SCALE_RND,
    S_MAC_RUN, S_MAC_DRAIN, S_EMIT
  } state_t;

  localparam logic [1:0] PASS_XY = 2'd0;
  localparam logic [1:0] PASS_Z  = 2'd1;
  localparam logic [1:0] PASS_M  = 2'd2;

  state_t             state;
  logic signed [31:0] base_scale;
  logic signed [31:0] vertical_offset;
  logic [31:0]        angle_x;
  logic [31:0]        angle_y;
  logic [31:0]        angle_z;
  logic signed [31:0] shift_x;
  logic signed [31:0] shift_y;
  logic signed [31:0] shift_z;
  logic signed [31:0] scale_factor;

  logic [1:0]         ang_sel;
  logic signed [31:0] cos_q [3];
  logic signed [31:0] sin_q [3];
  logic signed [31:0] m_y;
  logic signed [31:0] m_s;
  logic [1:0]         pass;
  logic [1:0]         row;
  logic [3:0]         cnt;
  logic               drain;

  logic signed [31:0] mat_a [16];
  logic signed [31:0] mat_b [16];
  logic signed [31:0] row_buf [4];

  logic signed [63:0] prod;
  logic               t1_v;
  logic               t1_first;
  logic               t1_last;
  logic [1:0]         t1_col;
  logic signed [65:0] acc;
  logic               t2_v;
  logic [1:0]         t2_col;

  logic [1:0]            k;
  logic [1:0]            j;
  logic signed [31:0]    left_v;
  logic signed [31:0]    right_v;
  logic signed [31:0]    m_elem;
  logic signed [31:0]    mul_a;
  logic signed [31:0]    mul_b;
  logic signed [31:0]    wr_val;
  logic [31:0]           cur_angle;
  mtmb_pkg::cordic_req_t cordic_req;
  mtmb_pkg::cordic_rsp_t cordic_rsp;

  mtmb_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (cordic_req),
    .rsp (cordic_rsp)
  );

  assign k = cnt[1:0];
  assign j = cnt[3:2];

  always_comb begin
    case (ang_sel)
      2'd0:    cur_angle = angle_x;
      2'd1:    cur_angle = angle_y;
      default: cur_angle = angle_z;
    endcase
  end

  assign cordic_req.start = (state == S_CORDIC_START);
  assign cordic_req.angle = cur_angle;

  // Translation and scale matrix entry at (k, j).
  always_comb begin
    m_elem = (k == j) ? mtmb_pkg::ONE_FIX : '0;
    if (j == 2'd3) begin
      case (k)
        2'd0:    m_elem = shift_x;
        2'd1:    m_elem = m_y;
        2'd2:    m_elem = shift_z;
        default: m_elem = m_s;
      endcase
    end
  end

  always_comb begin
    case (pass)
      PASS_XY: begin
        left_v  = mtmb_pkg::rot_elem(mtmb_pkg::AXIS_X, cos_q[0], sin_q[0], row, k);
        right_v = mtmb_pkg::rot_elem(mtmb_pkg::AXIS_Y, cos_q[1], sin_q[1], k, j);
      end
      PASS_Z: begin
        left_v  = mat_a[{row, k}];
        right_v = mtmb_pkg::rot_elem(mtmb_pkg::AXIS_Z, cos_q[2], sin_q[2], k, j);
      end
      default: begin
        left_v  = mat_b[{row, k}];
        right_v = m_elem;
      end
    endcase
  end

  assign mul_a  = (state == S_SCALE_MUL) ? scale_factor : left_v;
  assign mul_b  = (state == S_SCALE_MUL) ? base_scale : right_v;
  assign wr_val = mtmb_pkg::round_frac(acc);

  assign cmd.ready      = (state == S_IDLE);
  assign rows.valid     = (state == S_EMIT);
  assign rows.row_index = row;
  assign rows.col_zero  = row_buf[0];
  assign rows.col_one   = row_buf[1];
  assign rows.col_two   = row_buf[2];
  assign rows.col_three = row_buf[3];
  assign rows.last_row  = (row == 2'd3);

  always_ff @(posedge clk) begin
    // Shared multiplier and the accumulate and round stages behind it.
    prod <= 64'(mul_a) * 64'(mul_b);
    if (t1_v) begin
      acc <= (t1_first ? 66'sd0 : acc) + 66'(prod);
    end
    t2_col <= t1_col;
    if (t2_v) begin
      case (pass)
        PASS_XY: mat_a[{row, t2_col}] <= wr_val;
        PASS_Z:  mat_b[{row, t2_col}] <= wr_val;
        default: row_buf[t2_col] <= wr_val;
      endcase
    end

    if (rst) begin
      state           <= S_IDLE;
      base_scale      <= mtmb_pkg::ONE_FIX;
      vertical_offset <= '0;
      angle_x         <= '0;
      angle_y         <= '0;
      angle_z         <= '0;
      shift_x         <= '0;
      shift_y         <= '0;
      shift_z         <= '0;
      scale_factor    <= mtmb_pkg::ONE_FIX;
      t1_v            <= 1'b0;
      t2_v            <= 1'b0;
    end else begin
      t1_v     <= (state == S_MAC_RUN);
      t1_first <= (k == 2'd0);
      t1_last  <= (k == 2'd3);
      t1_col   <= j;
      t2_v     <= t1_v & t1_last;

      if (cfg_we) begin
        case (cfg_index)
          mtmb_pkg::REG_BASE_SCALE:  base_scale <= cfg_data;
          mtmb_pkg::REG_VERT_OFFSET: vertical_offset <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            case (cmd.command)
              mtmb_pkg::CMD_SET_ROT: begin
                case (cmd.axis)
                  mtmb_pkg::AXIS_X: angle_x <= cmd.operand_value;
                  mtmb_pkg::AXIS_Y: angle_y <= cmd.operand_value;
                  mtmb_pkg::AXIS_Z: angle_z <= cmd.operand_value;
                  default: ;
                endcase
              end
              mtmb_pkg::CMD_SET_MOVE: begin
                case (cmd.axis)
                  mtmb_pkg::AXIS_X: shift_x <= cmd.operand_value;
                  mtmb_pkg::AXIS_Y: shift_y <= cmd.operand_value;
                  mtmb_pkg::AXIS_Z: shift_z <= cmd.operand_value;
                  default:          scale_factor <= cmd.operand_value;
                endcase
              end
              mtmb_pkg::CMD_EMIT: begin
                m_y     <= mtmb_pkg::sat32(66'(shift_y) - 66'(vertical_offset));
                ang_sel <= 2'd0;
                state   <= S_CORDIC_START;
              end
              default: ;
            endcase
          end
        end
        S_CORDIC_START: begin
          state <= S_CORDIC_WAIT;
        end
        S_CORDIC_WAIT: begin
          if (cordic_rsp.done) begin
            cos_q[ang_sel] <= cordic_rsp.cos_v;
            sin_q[ang_sel] <= cordic_rsp.sin_v;
            if (ang_sel == 2'd2) begin
              state <= S_SCALE_MUL;
            end else begin
              ang_sel <= ang_sel + 1'b1;
              state   <= S_CORDIC_START;
            end
          end
        end
        S_SCALE_MUL: begin
          state <= S_SCALE_RND;
        end
        S_SCALE_RND: begin
          m_s   <= mtmb_pkg::round_frac(66'(prod));
          pass  <= PASS_XY;
          row   <= 2'd0;
          cnt   <= '0;
          state <= S_MAC_RUN;
        end
        S_MAC_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == 4'hF) begin
            drain <= 1'b0;
            state <= S_MAC_DRAIN;
          end
        end
        S_MAC_DRAIN: begin
          drain <= 1'b1;
          // The last entry of the row is written once drain is set, as the state leaves S_MAC_DRAIN.
          if (drain) begin
            if (pass == PASS_M) begin
              state <= S_EMIT;
            end else begin
              if (row == 2'd3) begin
                row  <= 2'd0;
                pass <= pass + 1'b1;
              end else begin
                row <= row + 1'b1;
              end
              cnt   <= '0;
              state <= S_MAC_RUN;
            end
          end
        end
        S_EMIT: begin
          if (rows.ready) begin
            if (row == 2'd3) begin
              state <= S_IDLE;
            end else begin
              row   <= row + 1'b1;
              cnt   <= '0;
              state <= S_MAC_RUN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/mtmb_checker.sv */
// ----------------------------------------------------------------------------
// mtmb_checker
// Port-level checks on the builder's command and row channels.
// ----------------------------------------------------------------------------
`include "model_transform_matrix_builder_assert.svh"

module mtmb_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] row_index,
  input logic       last_row
);

  `MTMB_ASSERT_NOW(a_last_marks_row3, out_valid, last_row == (row_index == 2'd3))
  `MTMB_ASSERT_NOW(a_busy_while_emit, out_valid, !cmd_ready)
  `MTMB_ASSERT_NEXT(a_more_rows_busy, out_valid && out_ready && !last_row, !cmd_ready)
  `MTMB_ASSERT_NEXT(a_idle_after_last, out_valid && out_ready && last_row, cmd_ready && !out_valid)
  `MTMB_ASSERT_NEXT(a_row_held, out_valid && !out_ready, out_valid && $stable(row_index))

endmodule

bind model_transform_matrix_builder mtmb_checker u_mtmb_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_ready (cmd.ready),
  .out_valid (rows.valid),
  .out_ready (rows.ready),
  .row_index (rows.row_index),
  .last_row  (rows.last_row)
);

/* bench/matrix_row_checker.sv */
// ----------------------------------------------------------------------------
// matrix_row_checker
// Watches the command, row and register channels of the matrix builder,
// predicts the four rows of every emitted matrix and compares them in order.
// ----------------------------------------------------------------------------
module matrix_row_checker
  import mtmb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  mtmb_cmd_if         cmd,
  mtmb_row_if         rows,
  output int          fail_count,
  output int          rows_pending,
  output int          rows_checked
);

  typedef logic signed [31:0] mat_t [4][4];

  typedef struct {
    logic [1:0]         row_index;
    logic signed [31:0] col [4];
    logic               last_row;
  } row_t;

  row_t row_queue [$];

  logic signed [31:0] base_scale, vert_offset;
  logic [31:0]        ang_x, ang_y, ang_z;
  logic signed [31:0] shift_x, shift_y, shift_z, scale_val;

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7fffffff;
    else if (v < -66'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Round half up to sh fraction bits, then clamp.
  function automatic logic signed [31:0] round_to(input logic signed [65:0] v,
                                                  input int sh);
    logic signed [65:0] t;
    t = (v + (66'sd1 <<< (sh - 1))) >>> sh;
    return clamp32(t);
  endfunction

  function automatic void sin_cos(input logic [31:0] a,
                                  output logic signed [31:0] c,
                                  output logic signed [31:0] s);
    logic [31:0] q;
    logic        flip;
    longint      x, y, z, dx, dy;
    q = a + 32'h40000000;
    flip = q[31];
    if (flip) a = a - 32'h80000000;
    x = 652032874;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'({32'd0, ATAN_TURNS[i]});
      end else begin
        x += dx; y -= dy; z += longint'({32'd0, ATAN_TURNS[i]});
      end
    end
    c = round_to(66'(x), CORDIC_SH);
    s = round_to(66'(y), CORDIC_SH);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic mat_t mat_mul(input mat_t a, input mat_t b);
    mat_t r;
    logic signed [65:0] acc;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) acc += 66'(a[i][k]) * 66'(b[k][j]);
        r[i][j] = round_to(acc, FRAC_BITS);
      end
    return r;
  endfunction

  function automatic mat_t unit_mat();
    mat_t m;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) m[i][j] = (i == j) ? ONE_FIX : '0;
    return m;
  endfunction

  task automatic queue_matrix();
    mat_t rx, ry, rz, mv, prod;
    logic signed [31:0] c, s;
    row_t r;
    rx = unit_mat(); ry = unit_mat(); rz = unit_mat(); mv = unit_mat();
    sin_cos(ang_x, c, s);
    rx[1][1] = c; rx[1][2] = s; rx[2][1] = -s; rx[2][2] = c;
    sin_cos(ang_y, c, s);
    ry[0][0] = c; ry[0][2] = -s; ry[2][0] = s; ry[2][2] = c;
    sin_cos(ang_z, c, s);
    rz[0][0] = c; rz[0][1] = s; rz[1][0] = -s; rz[1][1] = c;
    mv[0][3] = shift_x;
    mv[1][3] = clamp32(66'(shift_y) - 66'(vert_offset));
    mv[2][3] = shift_z;
    mv[3][3] = round_to(66'(scale_val) * 66'(base_scale), FRAC_BITS);
    prod = mat_mul(mat_mul(mat_mul(rx, ry), rz), mv);
    for (int i = 0; i < 4; i++) begin
      r.row_index = 2'(i);
      for (int j = 0; j < 4; j++) r.col[j] = prod[i][j];
      r.last_row = (i == 3);
      row_queue.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    rows_pending = 0;
    rows_checked = 0;
  end

  always @(posedge clk) begin
    row_t e;
    if (rst) begin
      base_scale <= ONE_FIX;
      vert_offset <= '0;
      ang_x <= '0; ang_y <= '0; ang_z <= '0;
      shift_x <= '0; shift_y <= '0; shift_z <= '0;
      scale_val <= ONE_FIX;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BASE_SCALE) base_scale <= cfg_data;
        else vert_offset <= cfg_data;
      end
      if (cmd.valid && cmd.ready) begin
        case (cmd.command)
          CMD_SET_ROT: begin
            case (cmd.axis)
              AXIS_X: ang_x <= cmd.operand_value;
              AXIS_Y: ang_y <= cmd.operand_value;
              AXIS_Z: ang_z <= cmd.operand_value;
              default: ;
            endcase
          end
          CMD_SET_MOVE: begin
            case (cmd.axis)
              AXIS_X: shift_x <= cmd.operand_value;
              AXIS_Y: shift_y <= cmd.operand_value;
              AXIS_Z: shift_z <= cmd.operand_value;
              default: scale_val <= cmd.operand_value;
            endcase
          end
          // An emit sees the stored values as they stood before this edge.
          CMD_EMIT: queue_matrix();
          default: ;
        endcase
      end
      if (rows.valid && rows.ready) begin
        if (row_queue.size() == 0) begin
          $error("row transfer with no matrix row expected");
          fail_count++;
        end else begin
          e = row_queue.pop_front();
          check_field("row_index", 32'(e.row_index), 32'(rows.row_index));
          check_field("col_zero", e.col[0], rows.col_zero);
          check_field("col_one", e.col[1], rows.col_one);
          check_field("col_two", e.col[2], rows.col_two);
          check_field("col_three", e.col[3], rows.col_three);
          check_field("last_row", 32'(e.last_row), 32'(rows.last_row));
          rows_checked++;
        end
      end
      rows_pending = row_queue.size();
    end
  end

endmodule

/* bench/model_transform_matrix_builder_tb.sv */
// ----------------------------------------------------------------------------
// model_transform_matrix_builder_tb
// Drives rotation, move and emit commands with random gaps and row stalls
// across several register settings; the checker predicts every matrix row.
// ----------------------------------------------------------------------------
module model_transform_matrix_builder_tb;
  import mtmb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        quiet;
  int          fail_count, rows_pending, rows_checked, cycles, cmds_sent;

  mtmb_cmd_if cmd ();
  mtmb_row_if rows ();

  model_transform_matrix_builder DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd(cmd), .rows(rows)
  );

  matrix_row_checker checker_inst (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd(cmd), .rows(rows), .fail_count(fail_count),
    .rows_pending(rows_pending), .rows_checked(rows_checked)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Ready drops at random about a fifth of the time, except in the quiet stretch.
  always @(negedge clk) rows.ready <= quiet || ($urandom_range(99) >= 20);

  task automatic send_cmd(input logic [1:0] c, input logic [1:0] ax,
                          input logic [31:0] v);
    if (!quiet) while ($urandom_range(99) < 20) @(negedge clk);
    cmd.command = c;
    cmd.axis = ax;
    cmd.operand_value = v;
    cmd.valid = 1'b1;
    do @(posedge clk); while (!cmd.ready);
    @(negedge clk);
    cmd.valid = 1'b0;
    cmds_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] v);
    wait (rows_pending == 0);
    repeat (300) @(negedge clk);
    cfg_index = idx;
    cfg_data = v;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_cmds(input int n);
    int k;
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      v = $urandom();
      if ($urandom_range(3) == 0) v = 32'($signed(16'($urandom())));
      if (k < 35) send_cmd(CMD_SET_ROT, 2'($urandom()), $urandom());
      else if (k < 70) send_cmd(CMD_SET_MOVE, 2'($urandom()), v);
      else if (k < 96) send_cmd(CMD_EMIT, 2'($urandom()), $urandom());
      else send_cmd(2'd3, 2'($urandom()), $urandom());
    end
  endtask

  initial begin
    cycles = 0;
    cmds_sent = 0;
    quiet = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_BASE_SCALE;
    cfg_data = '0;
    cmd.valid = 1'b0;
    cmd.command = CMD_SET_ROT;
    cmd.axis = AXIS_X;
    cmd.operand_value = '0;
    rows.ready = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed: reset matrix, quadrant edges, ignored commands, saturation.
    send_cmd(CMD_EMIT, AXIS_X, '0);
    send_cmd(CMD_SET_ROT, AXIS_X, 32'h40000000);
    send_cmd(CMD_SET_ROT, AXIS_Y, 32'hC0000000);
    send_cmd(CMD_SET_ROT, AXIS_Z, 32'h80000000);
    send_cmd(CMD_SET_ROT, AXIS_SCALE, 32'h12345678);
    send_cmd(2'd3, AXIS_SCALE, 32'hFFFFFFFF);
    send_cmd(CMD_EMIT, AXIS_SCALE, 32'hFFFFFFFF);
    send_cmd(CMD_SET_ROT, AXIS_X, 32'h3FFFFFFF);
    send_cmd(CMD_SET_ROT, AXIS_Y, 32'hFFFFFFFF);
    send_cmd(CMD_SET_ROT, AXIS_Z, 32'h7FFFFFFF);
    send_cmd(CMD_SET_MOVE, AXIS_X, 32'h7FFFFFFF);
    send_cmd(CMD_SET_MOVE, AXIS_Y, 32'h80000000);
    send_cmd(CMD_SET_MOVE, AXIS_Z, 32'h7FFFFFFF);
    send_cmd(CMD_SET_MOVE, AXIS_SCALE, 32'h7FFFFFFF);
    send_cmd(CMD_EMIT, AXIS_Y, '0);
    write_reg(REG_BASE_SCALE, 32'h7FFFFFFF);
    write_reg(REG_VERT_OFFSET, 32'h7FFFFFFF);
    send_cmd(CMD_EMIT, AXIS_Z, '0);
    send_cmd(CMD_SET_MOVE, AXIS_SCALE, 32'h80000000);
    send_cmd(CMD_SET_ROT, AXIS_X, 32'hBFFFFFFF);
    send_cmd(CMD_EMIT, AXIS_X, '0);

    // Random phases, each under a different register setting.
    random_cmds(40);
    write_reg(REG_BASE_SCALE, 32'h80000000);
    write_reg(REG_VERT_OFFSET, 32'h80000000);
    quiet = 1'b1;
    random_cmds(40);
    quiet = 1'b0;
    write_reg(REG_BASE_SCALE, $urandom());
    write_reg(REG_VERT_OFFSET, $urandom());
    random_cmds(40);
    write_reg(REG_BASE_SCALE, 32'($signed(18'($urandom()))));
    write_reg(REG_VERT_OFFSET, '0);
    random_cmds(40);

    wait (rows_pending == 0);
    repeat (300) @(negedge clk);
    $display("Sent %0d commands and checked %0d matrix rows", cmds_sent, rows_checked);
    $display("over five register settings with random gaps and stalls.");
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
